### rtl/core/rgbw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgbw_pkg;

   localparam int NUM_LEVELS = 6;
   localparam int LVL_IDX_W  = 3;
   localparam int NUM_OPS    = 8;
   localparam int OP_IDX_W   = 3;

   // level slots
   localparam logic [LVL_IDX_W-1:0] LVL_BRIGHT = 3'd0;
   localparam logic [LVL_IDX_W-1:0] LVL_CLEVEL = 3'd1;
   localparam logic [LVL_IDX_W-1:0] LVL_RED    = 3'd2;
   localparam logic [LVL_IDX_W-1:0] LVL_GREEN  = 3'd3;
   localparam logic [LVL_IDX_W-1:0] LVL_BLUE   = 3'd4;
   localparam logic [LVL_IDX_W-1:0] LVL_WTEMP  = 3'd5;

   // multiply/scale operations, in execution order
   localparam logic [OP_IDX_W-1:0] OP_RED       = 3'd0;
   localparam logic [OP_IDX_W-1:0] OP_GREEN     = 3'd1;
   localparam logic [OP_IDX_W-1:0] OP_BLUE      = 3'd2;
   localparam logic [OP_IDX_W-1:0] OP_WHITE     = 3'd3;
   localparam logic [OP_IDX_W-1:0] OP_COLD_FULL = 3'd4;
   localparam logic [OP_IDX_W-1:0] OP_COLD      = 3'd5;
   localparam logic [OP_IDX_W-1:0] OP_WARM_FULL = 3'd6;
   localparam logic [OP_IDX_W-1:0] OP_WARM      = 3'd7;

   // register indexes
   localparam logic [1:0] CSR_LIGHT_MODE  = 2'd0;
   localparam logic [1:0] CSR_COLOR_ORDER = 2'd1;
   localparam logic [1:0] CSR_CCT_ORDER   = 2'd2;

   // light modes
   localparam logic [2:0] MODE_DIMMER   = 3'd0;
   localparam logic [2:0] MODE_RGB      = 3'd1;
   localparam logic [2:0] MODE_RGBW     = 3'd2;
   localparam logic [2:0] MODE_CCT      = 3'd3;
   localparam logic [2:0] MODE_CCT_RGB  = 3'd4;

   // color orders
   localparam logic [2:0] ORDER_RGBW = 3'd0;
   localparam logic [2:0] ORDER_GBRW = 3'd1;
   localparam logic [2:0] ORDER_GRBW = 3'd2;
   localparam logic [2:0] ORDER_GRWB = 3'd3;
   localparam logic [2:0] ORDER_BRGW = 3'd4;

   // cct orders
   localparam logic [1:0] CCT_WWCC = 2'd0;
   localparam logic [1:0] CCT_WCWC = 2'd1;
   localparam logic [1:0] CCT_CWCW = 2'd2;
   localparam logic [1:0] CCT_CCWW = 2'd3;

   localparam logic [2:0] RESET_LIGHT_MODE = MODE_RGBW;

   localparam logic [7:0] FULL_DUTY   = 8'hFF;
   localparam logic [7:0] PERCENT_MAX = 8'd100;
   localparam logic [7:0] STEP_COLOR  = 8'd5;
   localparam logic [7:0] STEP_BRIGHT = 8'd1;

   // floor(p / 100) = (p * RECIP_100) >> RECIP_SHIFT for p < 91180
   localparam logic [16:0] RECIP_100   = 17'd83887;
   localparam int          RECIP_SHIFT = 23;
   localparam int          MUL_W       = 17;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic FUNC_SET  = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef struct packed {
      logic first;
      logic second;
   } mul_ctl_type;

   typedef struct packed {
      logic [2:0] light_mode;
      logic [2:0] color_order;
      logic [1:0] cct_order;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] white;
      logic [7:0] cold;
      logic [7:0] warm;
   } mix_vals_type;

   typedef struct packed {
      logic [7:0] duty_a;
      logic [7:0] duty_b;
      logic [7:0] duty_c;
      logic [7:0] duty_d;
      logic       status;
   } duty_set_type;

   function automatic logic [7:0] sat_level(input logic [7:0] v);
      sat_level = (v > PERCENT_MAX) ? PERCENT_MAX : v;
   endfunction

endpackage

`default_nettype wire

### rtl/core/rgbw_fade_step.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbw_fade_step
   import rgbw_pkg::*;
(
   input  wire logic [7:0] now_level,
   input  wire logic [7:0] goal_level,
   input  wire logic       big_step,
   output logic      [7:0] next_level
);

   logic [8:0] step;
   logic [8:0] now_up;
   logic [8:0] goal_up;

   always_comb begin
      step    = {1'b0, big_step ? STEP_COLOR : STEP_BRIGHT};
      now_up  = {1'b0, now_level} + step;
      goal_up = {1'b0, goal_level} + step;
      if (now_level < goal_level && now_up <= {1'b0, goal_level}) begin
         next_level = now_up[7:0];
      end else if (now_level > goal_level && {1'b0, now_level} >= goal_up) begin
         next_level = now_level - step[7:0];
      end else begin
         next_level = goal_level;
      end
   end

endmodule

`default_nettype wire

### rtl/core/rgbw_mul_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbw_mul_unit
   import rgbw_pkg::*;
(
   input  wire logic        clock,
   input  wire mul_ctl_type ctl,
   input  wire logic [7:0]  operand_a,
   input  wire logic [7:0]  operand_b,
   output logic      [7:0]  quotient
);

   // one multiplier: first pass a*b, second pass scales by 1/100
   logic [15:0]        prod_ff;
   logic [15:0]        prod_in;
   logic [MUL_W-1:0]   mul_x;
   logic [MUL_W-1:0]   mul_y;
   logic [2*MUL_W-1:0] mul_p;

   always_comb begin
      if (ctl.second) begin
         mul_x = {1'b0, prod_ff};
         mul_y = RECIP_100;
      end else begin
         mul_x = {9'd0, operand_a};
         mul_y = {9'd0, operand_b};
      end
      mul_p    = mul_x * mul_y;
      prod_in  = ctl.first ? mul_p[15:0] : prod_ff;
      quotient = mul_p[RECIP_SHIFT+7:RECIP_SHIFT];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

### rtl/core/rgbw_duty_map.sv
`timescale 1ns / 1ps
`default_nettype none

module rgbw_duty_map
   import rgbw_pkg::*;
(
   input  wire cfg_type      cfg,
   input  wire mix_vals_type vals,
   output duty_set_type      duties
);

   logic [7:0] w;

   always_comb begin
      duties = '0;
      w      = (cfg.light_mode == MODE_RGB) ? 8'd0 : vals.white;
      case (cfg.light_mode)
         MODE_DIMMER: begin
            duties = '{vals.white, vals.white, vals.white, vals.white, STATUS_OK};
         end
         MODE_RGB, MODE_RGBW: begin
            case (cfg.color_order)
               ORDER_RGBW: duties = '{vals.red, vals.green, vals.blue, w, STATUS_OK};
               ORDER_GBRW: duties = '{vals.green, vals.blue, vals.red, w, STATUS_OK};
               ORDER_GRBW: duties = '{vals.green, vals.red, vals.blue, w, STATUS_OK};
               ORDER_GRWB: duties = '{vals.green, vals.red, w, vals.blue, STATUS_OK};
               ORDER_BRGW: duties = '{vals.blue, vals.red, vals.green, w, STATUS_OK};
               default:    duties = '{8'd0, 8'd0, 8'd0, 8'd0, STATUS_ERR};
            endcase
         end
         MODE_CCT: begin
            case (cfg.cct_order)
               CCT_WWCC: duties = '{vals.warm, vals.warm, vals.cold, vals.cold, STATUS_OK};
               CCT_WCWC: duties = '{vals.warm, vals.cold, vals.warm, vals.cold, STATUS_OK};
               CCT_CWCW: duties = '{vals.cold, vals.warm, vals.cold, vals.warm, STATUS_OK};
               CCT_CCWW: duties = '{vals.cold, vals.cold, vals.warm, vals.warm, STATUS_OK};
               default:  duties = '{8'd0, 8'd0, 8'd0, 8'd0, STATUS_ERR};
            endcase
         end
         default: begin
            duties = '{8'd0, 8'd0, 8'd0, 8'd0, STATUS_ERR};
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/rgbw_fade_color_mixer_unit.sv
// RGBW LED fade mixer.
// Request channel (req_valid/req_stall): req_func 0 loads new targets (percent
// fields saturate at 100) and produces no response; req_func 1 is a fade tick.
// Response channel (rsp_valid/rsp_stall): one transaction per tick with four
// PWM duties in the configured output order and a status bit (1 = unsupported
// mode or order, duties zero).
// A target load is written into the targets as it is taken. A tick walks the
// six levels through one fade step per cycle, then runs eight multiply/scale
// operations on one shared multiplier, each a multiply step then a scale step,
// then loads the response register from its final step: rsp_valid rises and
// the next request can be taken in the same cycle.
// req_stall is high while a tick is in progress. If the response register is
// still held by rsp_stall when a tick finishes, the block waits in its final
// step; a new request is taken as soon as the result has moved into the
// response register, even if it has not yet been consumed.
// csr_write_en writes light_mode, color_order or cct_order; write only while
// idle. Synchronous reset clears all levels and targets, sets light_mode to
// rgb plus white and the orders to zero, and empties the response register.
`timescale 1ns / 1ps
`default_nettype none

module rgbw_fade_color_mixer_unit
   import rgbw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       csr_write_en,
   input  wire logic [1:0] csr_index,
   input  wire logic [2:0] csr_write_data,

   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_func,
   input  wire logic [6:0] req_tgt_brightness,
   input  wire logic [6:0] req_tgt_color_level,
   input  wire logic [7:0] req_tgt_red,
   input  wire logic [7:0] req_tgt_green,
   input  wire logic [7:0] req_tgt_blue,
   input  wire logic [6:0] req_tgt_white_temp,

   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_duty_a,
   output logic      [7:0] rsp_duty_b,
   output logic      [7:0] rsp_duty_c,
   output logic      [7:0] rsp_duty_d,
   output logic            rsp_status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_FADE  = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [LVL_IDX_W-1:0] lvl_idx_ff, lvl_idx_in;
   logic [OP_IDX_W-1:0]  op_ff, op_in;
   cfg_type              cfg_ff;
   logic [7:0]           cur_ff [NUM_LEVELS];
   logic [7:0]           tgt_ff [NUM_LEVELS];
   logic [7:0]           slot_ff [NUM_OPS];
   logic [7:0]           cur_level_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   duty_set_type         rsp_ff;

   logic                 req_take;
   logic                 rsp_take;
   logic                 rsp_load;
   mul_ctl_type          mul_ctl;
   logic [7:0]           operand_a;
   logic [7:0]           operand_b;
   logic [7:0]           quotient;
   logic [7:0]           br_sat;
   logic [7:0]           cb_sat;
   logic [7:0]           wt_sat;
   mix_vals_type         vals;
   duty_set_type         duties;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   rgbw_fade_step u_fade (
      .now_level  (cur_ff[lvl_idx_ff]),
      .goal_level (tgt_ff[lvl_idx_ff]),
      .big_step   (lvl_idx_ff >= LVL_RED),
      .next_level (cur_level_in)
   );

   always_comb begin
      br_sat = sat_level(cur_ff[LVL_BRIGHT]);
      cb_sat = sat_level(cur_ff[LVL_CLEVEL]);
      wt_sat = sat_level(cur_ff[LVL_WTEMP]);
      mul_ctl.first  = (state_ff == S_MUL);
      mul_ctl.second = (state_ff == S_SCALE);
      case (op_ff)
         OP_RED: begin
            operand_a = cur_ff[LVL_RED];
            operand_b = cb_sat;
         end
         OP_GREEN: begin
            operand_a = cur_ff[LVL_GREEN];
            operand_b = cb_sat;
         end
         OP_BLUE: begin
            operand_a = cur_ff[LVL_BLUE];
            operand_b = cb_sat;
         end
         OP_WHITE: begin
            operand_a = br_sat;
            operand_b = FULL_DUTY;
         end
         OP_COLD_FULL: begin
            operand_a = wt_sat;
            operand_b = FULL_DUTY;
         end
         OP_COLD: begin
            operand_a = slot_ff[OP_COLD_FULL];
            operand_b = br_sat;
         end
         OP_WARM_FULL: begin
            operand_a = PERCENT_MAX - wt_sat;
            operand_b = FULL_DUTY;
         end
         OP_WARM: begin
            operand_a = slot_ff[OP_WARM_FULL];
            operand_b = br_sat;
         end
         default: begin
            operand_a = 8'd0;
            operand_b = 8'd0;
         end
      endcase
   end

   rgbw_mul_unit u_mul (
      .clock     (clock),
      .ctl       (mul_ctl),
      .operand_a (operand_a),
      .operand_b (operand_b),
      .quotient  (quotient)
   );

   assign vals = '{slot_ff[OP_RED], slot_ff[OP_GREEN], slot_ff[OP_BLUE],
                   slot_ff[OP_WHITE], slot_ff[OP_COLD], slot_ff[OP_WARM]};

   rgbw_duty_map u_map (
      .cfg    (cfg_ff),
      .vals   (vals),
      .duties (duties)
   );

   always_comb begin
      state_in     = state_ff;
      lvl_idx_in   = lvl_idx_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_take && req_func == FUNC_TICK) begin
               state_in   = S_FADE;
               lvl_idx_in = LVL_BRIGHT;
            end
         end
         S_FADE: begin
            if (lvl_idx_ff == LVL_WTEMP) begin
               state_in = S_MUL;
               op_in    = OP_RED;
            end else begin
               lvl_idx_in = lvl_idx_ff + 3'd1;
            end
         end
         S_MUL: begin
            state_in = S_SCALE;
         end
         S_SCALE: begin
            if (op_ff == OP_WARM) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MUL;
               op_in    = op_ff + 3'd1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lvl_idx_ff   <= LVL_BRIGHT;
         op_ff        <= OP_RED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lvl_idx_ff   <= lvl_idx_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_mode  <= RESET_LIGHT_MODE;
         cfg_ff.color_order <= ORDER_RGBW;
         cfg_ff.cct_order   <= CCT_WWCC;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LIGHT_MODE:  cfg_ff.light_mode  <= csr_write_data;
            CSR_COLOR_ORDER: cfg_ff.color_order <= csr_write_data;
            CSR_CCT_ORDER:   cfg_ff.cct_order   <= csr_write_data[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            cur_ff[i] <= 8'd0;
            tgt_ff[i] <= 8'd0;
         end
      end else begin
         if (req_take && req_func == FUNC_SET) begin
            tgt_ff[LVL_BRIGHT] <= sat_level({1'b0, req_tgt_brightness});
            tgt_ff[LVL_CLEVEL] <= sat_level({1'b0, req_tgt_color_level});
            tgt_ff[LVL_RED]    <= req_tgt_red;
            tgt_ff[LVL_GREEN]  <= req_tgt_green;
            tgt_ff[LVL_BLUE]   <= req_tgt_blue;
            tgt_ff[LVL_WTEMP]  <= sat_level({1'b0, req_tgt_white_temp});
         end
         if (state_ff == S_FADE) begin
            cur_ff[lvl_idx_ff] <= cur_level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SCALE) begin
         slot_ff[op_ff] <= quotient;
      end
      if (rsp_load) begin
         rsp_ff <= duties;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty_a = rsp_ff.duty_a;
   assign rsp_duty_b = rsp_ff.duty_b;
   assign rsp_duty_c = rsp_ff.duty_c;
   assign rsp_duty_d = rsp_ff.duty_d;
   assign rsp_status = rsp_ff.status;

`ifndef SYNTH
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("response raised outside final step");

   a_tick_starts_fade: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_func == FUNC_TICK) |=> (state_ff == S_FADE && lvl_idx_ff == LVL_BRIGHT))
      else $error("tick did not start fade walk");

   a_set_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_func == FUNC_SET) |=> (state_ff == S_IDLE && !$rose(rsp_valid_ff)))
      else $error("target load left idle or produced a response");

   a_fade_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FADE && lvl_idx_ff == LVL_WTEMP) |=> (state_ff == S_MUL && op_ff == OP_RED))
      else $error("fade walk did not hand over to multiplier");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("free response register not loaded");
`endif

endmodule

`default_nettype wire
